// ----- rtl/core/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants for the projected triangle barycentric block.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int CoordW   = 16;
  localparam int FracBits = 16;
  localparam int WeightW  = 32;
  localparam int TolW     = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int CrossW   = ProdW + 1;
  localparam int ShW      = WeightW - FracBits;

  localparam logic signed [WeightW-1:0] OneFx      = WeightW'(1) << FracBits;
  localparam logic signed [WeightW-1:0] MinusOneFx = -OneFx;
  localparam logic signed [WeightW-1:0] WMax       = {1'b0, {(WeightW-1){1'b1}}};
  localparam logic signed [WeightW-1:0] WMin       = {1'b1, {(WeightW-1){1'b0}}};

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [DiffW-1:0]   diff_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [CrossW-1:0]  cross_t;
  typedef logic        [CrossW-1:0]  mag_t;
  typedef logic signed [WeightW-1:0] weight_t;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StDegen     = 2'd1,
    StSaturated = 2'd2
  } status_e;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } in_req_t;

  typedef struct packed {
    status_e status;
    weight_t weight_a;
    weight_t weight_b;
    weight_t weight_c;
  } out_rsp_t;

  typedef struct packed {
    mag_t num_u;
    mag_t num_v;
    mag_t den;
    logic neg_u;
    logic neg_v;
    logic flat;
  } div_in_t;

  typedef struct packed {
    logic [WeightW-1:0] q_u;
    logic [WeightW-1:0] q_v;
    logic               ovf_u;
    logic               ovf_v;
    logic               neg_u;
    logic               neg_v;
    logic               flat;
  } div_out_t;

endpackage

// ----- rtl/core/tbp_front.sv -----
// ----------------------------------------------------------------------------
// tbp_front
// Cross product, flat test, axis projection and 2D determinant/areas.
// ----------------------------------------------------------------------------
module tbp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tbp_pkg::TolW-1:0]   tol_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tbp_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tbp_pkg::div_in_t           out_o
);
  import tbp_pkg::*;

  localparam int NStg = 7;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   en;

  coord_t pt_in [4][3];
  coord_t pt1_q [4][3];
  coord_t pt2_q [4][3];
  coord_t pt3_q [4][3];
  diff_t  e1_q [3];
  diff_t  f1_q [3];
  prod_t  pr2_q [6];
  mag_t   mag3_q [3];
  logic   flat3_q, flat4_q, flat5_q, flat6_q;
  diff_t  pj4_q [6];
  prod_t  pr5_q [6];
  cross_t det6_q, a1_6_q, a2_6_q;
  div_in_t s7_q;

  assign pt_in[0][0] = in_req_i.vertex_a_x;
  assign pt_in[0][1] = in_req_i.vertex_a_y;
  assign pt_in[0][2] = in_req_i.vertex_a_z;
  assign pt_in[1][0] = in_req_i.vertex_b_x;
  assign pt_in[1][1] = in_req_i.vertex_b_y;
  assign pt_in[1][2] = in_req_i.vertex_b_z;
  assign pt_in[2][0] = in_req_i.vertex_c_x;
  assign pt_in[2][1] = in_req_i.vertex_c_y;
  assign pt_in[2][2] = in_req_i.vertex_c_z;
  assign pt_in[3][0] = in_req_i.query_x;
  assign pt_in[3][1] = in_req_i.query_y;
  assign pt_in[3][2] = in_req_i.query_z;

  always_comb begin
    en[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];
  assign out_o       = s7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 3 combinational: normal and flat test
  cross_t nrm [3];
  mag_t   nmag [3];
  logic   flat_d;
  always_comb begin
    nrm[0] = CrossW'(pr2_q[0]) - CrossW'(pr2_q[1]);
    nrm[1] = CrossW'(pr2_q[2]) - CrossW'(pr2_q[3]);
    nrm[2] = CrossW'(pr2_q[4]) - CrossW'(pr2_q[5]);
    for (int k = 0; k < 3; k++) begin
      nmag[k] = nrm[k][CrossW-1] ? mag_t'(-nrm[k]) : mag_t'(nrm[k]);
    end
    flat_d = (nmag[0] <= CrossW'(tol_i)) && (nmag[1] <= CrossW'(tol_i)) &&
             (nmag[2] <= CrossW'(tol_i));
  end

  // stage 4 combinational: projection
  logic [1:0] i0, i1;
  coord_t x1, y1, x2, y2, x3, y3, xp, yp;
  always_comb begin
    if (mag3_q[0] >= mag3_q[1] && mag3_q[0] >= mag3_q[2]) begin
      i0 = 2'd1;
      i1 = 2'd2;
    end else if (mag3_q[1] >= mag3_q[2]) begin
      i0 = 2'd0;
      i1 = 2'd2;
    end else begin
      i0 = 2'd0;
      i1 = 2'd1;
    end
    x1 = pt3_q[0][i0];
    y1 = pt3_q[0][i1];
    x2 = pt3_q[1][i0];
    y2 = pt3_q[1][i1];
    x3 = pt3_q[2][i0];
    y3 = pt3_q[2][i1];
    xp = pt3_q[3][i0];
    yp = pt3_q[3][i1];
  end

  // stage 7 combinational: signs and magnitudes
  div_in_t s7_d;
  always_comb begin
    s7_d.den   = det6_q[CrossW-1] ? mag_t'(-det6_q) : mag_t'(det6_q);
    s7_d.num_u = a1_6_q[CrossW-1] ? mag_t'(-a1_6_q) : mag_t'(a1_6_q);
    s7_d.num_v = a2_6_q[CrossW-1] ? mag_t'(-a2_6_q) : mag_t'(a2_6_q);
    s7_d.neg_u = a1_6_q[CrossW-1] ^ det6_q[CrossW-1];
    s7_d.neg_v = a2_6_q[CrossW-1] ^ det6_q[CrossW-1];
    s7_d.flat  = flat6_q || (det6_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pt1_q <= pt_in;
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= DiffW'(pt_in[1][k]) - DiffW'(pt_in[0][k]);
        f1_q[k] <= DiffW'(pt_in[2][k]) - DiffW'(pt_in[0][k]);
      end
    end
    if (en[1]) begin
      pt2_q    <= pt1_q;
      pr2_q[0] <= ProdW'(e1_q[1]) * ProdW'(f1_q[2]);
      pr2_q[1] <= ProdW'(e1_q[2]) * ProdW'(f1_q[1]);
      pr2_q[2] <= ProdW'(e1_q[2]) * ProdW'(f1_q[0]);
      pr2_q[3] <= ProdW'(e1_q[0]) * ProdW'(f1_q[2]);
      pr2_q[4] <= ProdW'(e1_q[0]) * ProdW'(f1_q[1]);
      pr2_q[5] <= ProdW'(e1_q[1]) * ProdW'(f1_q[0]);
    end
    if (en[2]) begin
      pt3_q   <= pt2_q;
      mag3_q  <= nmag;
      flat3_q <= flat_d;
    end
    if (en[3]) begin
      flat4_q  <= flat3_q;
      pj4_q[0] <= DiffW'(x1) - DiffW'(x3);
      pj4_q[1] <= DiffW'(y2) - DiffW'(y3);
      pj4_q[2] <= DiffW'(x2) - DiffW'(x3);
      pj4_q[3] <= DiffW'(y1) - DiffW'(y3);
      pj4_q[4] <= DiffW'(xp) - DiffW'(x3);
      pj4_q[5] <= DiffW'(yp) - DiffW'(y3);
    end
    if (en[4]) begin
      flat5_q  <= flat4_q;
      pr5_q[0] <= ProdW'(pj4_q[0]) * ProdW'(pj4_q[1]);
      pr5_q[1] <= ProdW'(pj4_q[2]) * ProdW'(pj4_q[3]);
      pr5_q[2] <= ProdW'(pj4_q[1]) * ProdW'(pj4_q[4]);
      pr5_q[3] <= ProdW'(pj4_q[2]) * ProdW'(pj4_q[5]);
      pr5_q[4] <= ProdW'(pj4_q[3]) * ProdW'(pj4_q[4]);
      pr5_q[5] <= ProdW'(pj4_q[0]) * ProdW'(pj4_q[5]);
    end
    if (en[5]) begin
      flat6_q <= flat5_q;
      det6_q  <= CrossW'(pr5_q[0]) - CrossW'(pr5_q[1]);
      a1_6_q  <= CrossW'(pr5_q[2]) - CrossW'(pr5_q[3]);
      a2_6_q  <= CrossW'(pr5_q[5]) - CrossW'(pr5_q[4]);
    end
    if (en[6]) begin
      s7_q <= s7_d;
    end
  end

endmodule

// ----- rtl/core/tbp_div.sv -----
// ----------------------------------------------------------------------------
// tbp_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbp_pkg::div_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbp_pkg::div_out_t out_o
);
  import tbp_pkg::*;

  localparam int NStg = WeightW + 1;

  typedef struct packed {
    mag_t               r;
    logic [WeightW-1:0] lo;
    logic [WeightW-1:0] q;
  } lane_t;

  typedef struct packed {
    lane_t u;
    lane_t v;
    mag_t  den;
    logic  ovf_u;
    logic  ovf_v;
    logic  neg_u;
    logic  neg_v;
    logic  flat;
  } dstg_t;

  function automatic lane_t lane_init(mag_t n);
    lane_t l;
    l.r  = mag_t'(n >> ShW);
    l.lo = {n[ShW-1:0], {FracBits{1'b0}}};
    l.q  = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, mag_t d);
    lane_t         o;
    logic [CrossW:0] r2;
    logic          ge;
    r2   = {l.r, l.lo[WeightW-1]};
    ge   = r2 >= {1'b0, d};
    o.r  = ge ? mag_t'(r2 - {1'b0, d}) : mag_t'(r2);
    o.lo = {l.lo[WeightW-2:0], 1'b0};
    o.q  = {l.q[WeightW-2:0], ge};
    return o;
  endfunction

  logic [NStg-1:0] v_q;
  logic [NStg:0]   en;
  dstg_t           st_q [NStg];
  dstg_t           st_d [NStg];

  always_comb begin
    en[NStg] = out_ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_comb begin
    st_d[0].u     = lane_init(in_i.num_u);
    st_d[0].v     = lane_init(in_i.num_v);
    st_d[0].den   = in_i.den;
    st_d[0].ovf_u = {{ShW{1'b0}}, in_i.num_u} >= {in_i.den, {ShW{1'b0}}};
    st_d[0].ovf_v = {{ShW{1'b0}}, in_i.num_v} >= {in_i.den, {ShW{1'b0}}};
    st_d[0].neg_u = in_i.neg_u;
    st_d[0].neg_v = in_i.neg_v;
    st_d[0].flat  = in_i.flat;
    for (int k = 1; k < NStg; k++) begin
      st_d[k]   = st_q[k-1];
      st_d[k].u = lane_step(st_q[k-1].u, st_q[k-1].den);
      st_d[k].v = lane_step(st_q[k-1].v, st_q[k-1].den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  always_comb begin
    out_o.q_u   = st_q[NStg-1].u.q;
    out_o.q_v   = st_q[NStg-1].v.q;
    out_o.ovf_u = st_q[NStg-1].ovf_u;
    out_o.ovf_v = st_q[NStg-1].ovf_v;
    out_o.neg_u = st_q[NStg-1].neg_u;
    out_o.neg_v = st_q[NStg-1].neg_v;
    out_o.flat  = st_q[NStg-1].flat;
  end

endmodule

// ----- rtl/core/tbp_back.sv -----
// ----------------------------------------------------------------------------
// tbp_back
// Sign restore, weight saturation, third weight and result register.
// ----------------------------------------------------------------------------
module tbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbp_pkg::div_out_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tbp_pkg::out_rsp_t out_o
);
  import tbp_pkg::*;

  localparam logic [WeightW-1:0] NegLimit = {1'b1, {(WeightW-1){1'b0}}};

  logic [1:0] v_q;
  logic [2:0] en;
  weight_t    u_q, v1_q;
  logic       sat1_q, flat1_q;
  out_rsp_t   rsp_q;

  weight_t u_d, v_d;
  logic    sat_u, sat_v;

  always_comb begin
    en[2] = out_ready_i;
    en[1] = ~v_q[1] | en[2];
    en[0] = ~v_q[0] | en[1];
  end

  always_comb begin
    sat_u = 1'b0;
    sat_v = 1'b0;
    if (in_i.neg_u) begin
      sat_u = in_i.ovf_u || (in_i.q_u > NegLimit);
      u_d   = sat_u ? WMin : weight_t'(-in_i.q_u);
    end else begin
      sat_u = in_i.ovf_u || in_i.q_u[WeightW-1];
      u_d   = sat_u ? WMax : weight_t'(in_i.q_u);
    end
    if (in_i.neg_v) begin
      sat_v = in_i.ovf_v || (in_i.q_v > NegLimit);
      v_d   = sat_v ? WMin : weight_t'(-in_i.q_v);
    end else begin
      sat_v = in_i.ovf_v || in_i.q_v[WeightW-1];
      v_d   = sat_v ? WMax : weight_t'(in_i.q_v);
    end
  end

  logic signed [WeightW+1:0] w_full;
  weight_t                   w_d;
  logic                      sat_w;
  out_rsp_t                  rsp_d;

  always_comb begin
    w_full = (WeightW+2)'(OneFx) - (WeightW+2)'(u_q) - (WeightW+2)'(v1_q);
    sat_w  = 1'b0;
    w_d    = weight_t'(w_full);
    if (w_full > (WeightW+2)'(WMax)) begin
      sat_w = 1'b1;
      w_d   = WMax;
    end else if (w_full < (WeightW+2)'(WMin)) begin
      sat_w = 1'b1;
      w_d   = WMin;
    end
    if (flat1_q) begin
      rsp_d.status   = StDegen;
      rsp_d.weight_a = MinusOneFx;
      rsp_d.weight_b = MinusOneFx;
      rsp_d.weight_c = MinusOneFx;
    end else begin
      rsp_d.status   = (sat1_q || sat_w) ? StSaturated : StOk;
      rsp_d.weight_a = u_q;
      rsp_d.weight_b = v1_q;
      rsp_d.weight_c = w_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (en[1]) begin
        v_q[1] <= v_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q     <= u_d;
      v1_q    <= v_d;
      sat1_q  <= sat_u | sat_v;
      flat1_q <= in_i.flat;
    end
    if (en[1]) begin
      rsp_q <= rsp_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[1];
  assign out_o       = rsp_q;

endmodule

// ----- rtl/core/triangle_barycentric_projected.sv -----
// ----------------------------------------------------------------------------
// triangle_barycentric_projected
// Barycentric weights of a 3D query point against a projected triangle.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output side keeps up and returns one
// result per request, in order, through 42 register stages: 7 stages form the
// cross product, flat test, projection and determinant, 33 stages are the
// two-lane divider (overflow check, then one quotient bit per stage), and 2
// stages saturate the weights and hold the result. A stalled output only holds
// stages that carry valid data; empty stages keep filling.
// zero_tolerance may be written only while no request is in flight.
// ----------------------------------------------------------------------------
module triangle_barycentric_projected (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tbp_pkg::TolW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tbp_pkg::in_req_t         in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tbp_pkg::out_rsp_t        out_rsp_o
);
  import tbp_pkg::*;

  logic [TolW-1:0] tol_q;
  logic            fr_valid, fr_ready, dv_valid, dv_ready;
  div_in_t         fr_data;
  div_out_t        dv_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  tbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr_data)
  );

  tbp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_i        (fr_data),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_o       (dv_data)
  );

  tbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .in_i        (dv_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_rsp_o)
  );

`ifndef SYNTHESIS
  a_degen_weights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == StDegen |->
      out_rsp_o.weight_a == MinusOneFx && out_rsp_o.weight_b == MinusOneFx &&
      out_rsp_o.weight_c == MinusOneFx)
    else $error("degenerate result with wrong weights");

  a_ok_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == StOk |->
      out_rsp_o.weight_c == weight_t'(OneFx - out_rsp_o.weight_a - out_rsp_o.weight_b))
    else $error("weights do not sum to one");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("pipeline blocked while output drains");
`endif

endmodule
